[hw/rtl/lrpe_pkg.sv]
// Shared types, result kinds and controller states of the LR parse engine.
package lrpe_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_ENTRY = 2'd0,
    ACT_LOAD_RULE  = 2'd1,
    ACT_TOKEN      = 2'd2,
    ACT_RESTART    = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_SHIFT  = 2'd1,
    CMD_REDUCE = 2'd2,
    CMD_GOTO   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_REDUCE = 3'd0,
    KIND_SHIFT  = 3'd1,
    KIND_ACCEPT = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_DONE   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACT_RD,
    ST_ACT_EVAL,
    ST_RULE_EVAL,
    ST_UNDER_RD,
    ST_GOTO_RD,
    ST_GOTO_EVAL,
    ST_EMIT,
    ST_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] state_index;
    logic [5:0] symbol;
    logic [1:0] command;
    logic [7:0] target;
    logic [6:0] rule_index;
    logic [3:0] rule_length;
    logic [5:0] rule_lhs;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] rule_reduced;
    logic [7:0] top_state;
    logic [6:0] stack_depth;
    logic       last;
  } out_item_t;

  localparam int unsigned RegStartState   = 0;
  localparam int unsigned RegAcceptSymbol = 1;

  // Table and stack sizes; the field widths above are sized for them.
  localparam int unsigned NumStates  = 256;
  localparam int unsigned NumSymbols = 64;
  localparam int unsigned NumRules   = 128;
  localparam int unsigned StackDepth = 64;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       latch_in;     // capture the accepted transaction
    logic       do_load;      // write table or rule entry
    logic       do_restart;
    logic       act_rd;       // read entry for (top, token)
    logic       rule_rd;      // read rule named by the entry
    logic       under_rd;     // read the uncovered stack state
    logic       goto_rd;      // read goto (uncovered, lhs)
    logic       do_reduce;    // pop length, push goto state
    logic       do_shift;     // push shift target
    logic       do_accept;    // pop length, no push
    logic       set_halt;
    logic       clr_red;
    logic       out_load;
    logic [2:0] out_kind;
    logic       out_rule;     // report the reduced rule
    logic       out_last;
  } ctl_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic [1:0] act;
    logic       tok_bad;      // halted or stack empty
    logic [1:0] ent_cmd;
    logic       ent_shift_ok;
    logic       ent_reduce_ok;
    logic       rule_under;
    logic       rule_accept;
    logic       goto_ok;
    logic       out_busy;
  } sts_t;

endpackage

[hw/rtl/lrpe_ctrl.sv]
// Controller state machine of the LR parse engine.
module lrpe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lrpe_pkg::sts_t  sts_i,
  output lrpe_pkg::ctl_t  ctl_o
);
  import lrpe_pkg::*;

  state_e state_q, state_d;
  kind_e  ekind_q, ekind_d;
  logic   elast_q, elast_d;
  logic   erule_q, erule_d;

  // Hold the state and the pending result kind, last flag and rule flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ekind_q <= KIND_DONE;
      elast_q <= 1'b0;
      erule_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ekind_q <= ekind_d;
      elast_q <= elast_d;
      erule_q <= erule_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    ekind_d = ekind_q;
    elast_d = elast_q;
    erule_d = erule_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ACT_RD;
      end
      ST_ACT_RD: begin
        // Loads, restarts and bad tokens finish here; any other token starts its lookup.
        if (sts_i.act == ACT_TOKEN) begin
          if (sts_i.tok_bad) begin
            state_d = ST_EMIT; ekind_d = KIND_ERROR; elast_d = 1'b1; erule_d = 1'b0;
          end else begin
            state_d = ST_ACT_EVAL;
          end
        end else begin
          state_d = ST_EMIT; ekind_d = KIND_DONE; elast_d = 1'b1; erule_d = 1'b0;
        end
      end
      ST_ACT_EVAL: begin
        if (sts_i.ent_cmd == CMD_SHIFT && sts_i.ent_shift_ok) begin
          state_d = ST_EMIT; ekind_d = KIND_SHIFT; elast_d = 1'b1; erule_d = 1'b0;
        end else if (sts_i.ent_cmd == CMD_REDUCE && sts_i.ent_reduce_ok) begin
          state_d = ST_RULE_EVAL;
        end else begin
          state_d = ST_EMIT; ekind_d = KIND_ERROR; elast_d = 1'b1; erule_d = 1'b0;
        end
      end
      ST_RULE_EVAL: begin
        if (sts_i.rule_under) begin
          state_d = ST_EMIT; ekind_d = KIND_ERROR; elast_d = 1'b1; erule_d = 1'b0;
        end else if (sts_i.rule_accept) begin
          state_d = ST_EMIT; ekind_d = KIND_ACCEPT; elast_d = 1'b1; erule_d = 1'b1;
        end else begin
          state_d = ST_UNDER_RD;
        end
      end
      ST_UNDER_RD: state_d = ST_GOTO_RD;
      ST_GOTO_RD:  state_d = ST_GOTO_EVAL;
      ST_GOTO_EVAL: begin
        if (sts_i.goto_ok) begin
          state_d = ST_EMIT; ekind_d = KIND_REDUCE; elast_d = 1'b0; erule_d = 1'b1;
        end else begin
          state_d = ST_EMIT; ekind_d = KIND_ERROR; elast_d = 1'b1; erule_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) state_d = elast_q ? ST_IDLE : ST_OUT_WAIT;
      end
      ST_OUT_WAIT: state_d = ST_ACT_RD;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.latch_in = in_valid_i;
        ctl_o.clr_red  = in_valid_i;
      end
      ST_ACT_RD: begin
        ctl_o.act_rd = (sts_i.act == ACT_TOKEN) && !sts_i.tok_bad;
        ctl_o.do_load = (sts_i.act == ACT_LOAD_ENTRY) || (sts_i.act == ACT_LOAD_RULE);
        ctl_o.do_restart = (sts_i.act == ACT_RESTART);
        ctl_o.set_halt = (sts_i.act == ACT_TOKEN) && sts_i.tok_bad;
      end
      ST_ACT_EVAL: begin
        ctl_o.do_shift = (sts_i.ent_cmd == CMD_SHIFT) && sts_i.ent_shift_ok;
        ctl_o.rule_rd  = (sts_i.ent_cmd == CMD_REDUCE) && sts_i.ent_reduce_ok;
        ctl_o.set_halt = !(ctl_o.do_shift || ctl_o.rule_rd);
      end
      ST_RULE_EVAL: begin
        ctl_o.do_accept = !sts_i.rule_under && sts_i.rule_accept;
        ctl_o.set_halt  = sts_i.rule_under || sts_i.rule_accept;
        ctl_o.under_rd  = !sts_i.rule_under && !sts_i.rule_accept;
      end
      ST_GOTO_RD: ctl_o.goto_rd = 1'b1;
      ST_GOTO_EVAL: begin
        ctl_o.do_reduce = sts_i.goto_ok;
        ctl_o.set_halt  = !sts_i.goto_ok;
      end
      ST_EMIT: begin
        ctl_o.out_load = !sts_i.out_busy;
        ctl_o.out_kind = ekind_q;
        ctl_o.out_rule = erule_q;
        ctl_o.out_last = elast_q;
      end
      ST_OUT_WAIT: ctl_o.act_rd = 1'b1;
      default: ;
    endcase
  end

endmodule

[hw/rtl/lrpe_dpath.sv]
// Datapath of the LR parse engine: tables, state stack and result register.
module lrpe_dpath #(
  parameter int unsigned MAX_REDUCTIONS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrpe_pkg::in_item_t   in_data_i,
  input  logic [7:0]           start_state_i,
  input  logic [5:0]           accept_symbol_i,
  input  lrpe_pkg::ctl_t       ctl_i,
  output lrpe_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lrpe_pkg::out_item_t  out_data_o
);
  import lrpe_pkg::*;

  localparam int unsigned StW  = (NumStates  > 1) ? $clog2(NumStates)  : 1;
  localparam int unsigned SymW = (NumSymbols > 1) ? $clog2(NumSymbols) : 1;
  localparam int unsigned RuW  = (NumRules   > 1) ? $clog2(NumRules)   : 1;
  localparam int unsigned SkW  = $clog2(StackDepth);
  localparam int unsigned SpW  = $clog2(StackDepth + 1);
  localparam int unsigned AdW  = StW + SymW;
  localparam int unsigned RdW  = $clog2(MAX_REDUCTIONS + 1);

  logic [9:0]  act_mem  [NumStates*NumSymbols];
  logic [9:0]  rule_mem [NumRules];
  logic [7:0]  stk_mem  [StackDepth];

  in_item_t       in_q;
  logic [SpW-1:0] sp_q;
  logic           halted_q;
  logic [5:0]     lhs_q;
  logic [RdW-1:0] red_q;
  logic [7:0]     top_q;
  logic [9:0]     ent_q;
  logic [9:0]     rul_q;
  logic [7:0]     und_q;
  logic [6:0]     rnum_q;
  logic           lk_oor_q, go_oor_q;
  logic           out_valid_q;
  out_item_t      out_q;

  // Capture the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) in_q <= in_data_i;
  end

  // Table writes and reads.
  logic [AdW-1:0] act_rd_addr;
  logic           act_rd_en;
  logic [7:0]     lk_state;
  logic [5:0]     lk_sym;
  always_comb begin
    lk_state = ctl_i.goto_rd ? und_q : top_q;
    lk_sym   = ctl_i.goto_rd ? rul_q[5:0] : in_q.symbol;
    act_rd_en = ctl_i.act_rd || ctl_i.goto_rd;
    act_rd_addr = {lk_state[StW-1:0], lk_sym[SymW-1:0]};
  end

  logic lk_oor;
  assign lk_oor = (32'(lk_state) >= NumStates) || (32'(lk_sym) >= NumSymbols);

  always_ff @(posedge clk_i) begin
    if (ctl_i.do_load && in_q.action == ACT_LOAD_ENTRY
        && 32'(in_q.state_index) < NumStates && 32'(in_q.symbol) < NumSymbols)
      act_mem[{in_q.state_index[StW-1:0], in_q.symbol[SymW-1:0]}]
        <= {in_q.command, in_q.target};
    if (act_rd_en) begin
      ent_q    <= act_mem[act_rd_addr];
      lk_oor_q <= lk_oor;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.do_load && in_q.action == ACT_LOAD_RULE && 32'(in_q.rule_index) < NumRules)
      rule_mem[in_q.rule_index[RuW-1:0]] <= {in_q.rule_length, in_q.rule_lhs};
    if (ctl_i.rule_rd) begin
      rul_q  <= rule_mem[ent_q[RuW-1:0]];
      rnum_q <= ent_q[6:0];
    end
  end

  // Effective entry: outside the table reads as none.
  logic [1:0] ecmd;
  assign ecmd = lk_oor_q ? CMD_NONE : ent_q[9:8];

  logic [3:0]     rlen;
  logic [SpW-1:0] sp_pop;
  assign rlen   = rul_q[9:6];
  assign sp_pop = sp_q - SpW'(rlen);

  // Stack write port, pointer update and registered read of the uncovered entry.
  logic           stk_we;
  logic [SkW-1:0] stk_wa;
  logic [7:0]     stk_wd;
  logic [SpW-1:0] sp_d;
  always_comb begin
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = '0;
    sp_d   = sp_q;
    if (ctl_i.do_restart) begin
      stk_we = 1'b1; stk_wd = start_state_i; sp_d = SpW'(1);
    end else if (ctl_i.do_shift) begin
      stk_we = 1'b1; stk_wa = sp_q[SkW-1:0]; stk_wd = ent_q[7:0]; sp_d = sp_q + 1'b1;
    end else if (ctl_i.do_reduce) begin
      stk_we = 1'b1; stk_wa = sp_pop[SkW-1:0]; stk_wd = ent_q[7:0]; sp_d = sp_pop + 1'b1;
    end else if (ctl_i.do_accept) begin
      sp_d = sp_pop;
    end
  end

  logic [SpW-1:0] sp_m1;
  assign sp_m1 = sp_pop - 1'b1;

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (ctl_i.under_rd) und_q <= stk_mem[sp_m1[SkW-1:0]];
  end

  // Top of stack tracked in a register so it is ready before each lookup.
  logic [7:0] top_d;
  always_comb begin
    top_d = top_q;
    if (stk_we) top_d = stk_wd;
    else if (ctl_i.do_accept) top_d = (sp_pop == '0) ? 8'd0 : und_q;
  end

  // Accept needs the uncovered state for top; read it early.
  logic [SpW-1:0] acc_m1;
  logic [7:0]     acc_top_q;
  assign acc_m1 = sp_pop - 1'b1;
  always_ff @(posedge clk_i) begin
    if (ctl_i.rule_rd) go_oor_q <= 1'b0;
    if (ctl_i.do_accept) acc_top_q <= stk_mem[acc_m1[SkW-1:0]];
  end

  logic acc_fix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= '0;
      halted_q  <= 1'b1;
      lhs_q     <= '0;
      red_q     <= '0;
      top_q     <= '0;
      acc_fix_q <= 1'b0;
    end else begin
      sp_q      <= sp_d;
      acc_fix_q <= ctl_i.do_accept && (sp_pop != '0);
      top_q     <= acc_fix_q ? acc_top_q : (ctl_i.do_accept ? 8'd0 : top_d);
      if (ctl_i.do_restart) begin
        halted_q <= 1'b0; lhs_q <= '0;
      end else if (ctl_i.set_halt) begin
        halted_q <= 1'b1;
      end
      if (ctl_i.do_reduce || ctl_i.do_accept) lhs_q <= rul_q[5:0];
      if (ctl_i.clr_red) red_q <= '0;
      else if (ctl_i.do_reduce) red_q <= red_q + 1'b1;
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.act           = in_q.action;
    sts_o.tok_bad       = halted_q || (sp_q == '0);
    sts_o.ent_cmd       = ecmd;
    sts_o.ent_shift_ok  = (32'(sp_q) < StackDepth);
    sts_o.ent_reduce_ok = (32'(ent_q[7:0]) < NumRules) && (32'(red_q) < MAX_REDUCTIONS);
    sts_o.rule_under    = (SpW'(rlen) >= sp_q) || (32'(rlen) >= 32'(sp_q));
    sts_o.rule_accept   = (rul_q[5:0] == accept_symbol_i);
    sts_o.goto_ok       = !lk_oor_q && (ent_q[9:8] == CMD_GOTO)
                          && (32'(sp_pop) < StackDepth) && !go_oor_q;
    sts_o.out_busy      = out_valid_q && out_stall_i;
  end

  // Result register; fields sampled after the stack update settles.
  // Right after an accept the uncovered state is still in the early read register.
  logic       pend_q;
  out_item_t  pend_d;
  always_comb begin
    pend_d.kind         = ctl_i.out_kind;
    pend_d.rule_reduced = ctl_i.out_rule ? rnum_q : 7'd0;
    pend_d.top_state    = acc_fix_q ? acc_top_q : top_q;
    pend_d.stack_depth  = 7'(sp_q);
    pend_d.last         = ctl_i.out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      pend_q <= 1'b0;
      if (ctl_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) out_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic unused;
  assign unused = pend_q ^ lhs_q[0];

endmodule

[hw/rtl/lr_parse_engine.sv]
// Top level of the LR parse engine: configuration registers, controller, datapath.
// A load, a restart or a token while halted gives its result after the first step; a shift
// or entry error after the entry read, an accept or rule error after the rule read, and a
// reduction or goto error after the uncovered-state and goto reads. Each later result of
// one token repeats the lookup from the entry read, and a stalled output holds it back.
// One item at a time: the next item is accepted once the final result is registered.
// Reset: stack empty, engine halted until a restart, registers zero; tables undefined.
module lr_parse_engine #(
  parameter int unsigned MAX_REDUCTIONS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lrpe_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lrpe_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lrpe_pkg::*;

  logic [7:0] start_state_q;
  logic [5:0] accept_symbol_q;
  ctl_t ctl;
  sts_t sts;

  assign pready = 1'b1;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q   <= '0;
      accept_symbol_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (32'(paddr[2]))
        RegStartState:   start_state_q   <= pwdata[7:0];
        RegAcceptSymbol: accept_symbol_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2]) prdata = {26'd0, accept_symbol_q};
      else          prdata = {24'd0, start_state_q};
    end
  end

  lrpe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .ctl_o(ctl)
  );

  lrpe_dpath #(
    .MAX_REDUCTIONS(MAX_REDUCTIONS)
  ) u_dpath (
    .clk_i, .rst_ni, .in_data_i,
    .start_state_i(start_state_q), .accept_symbol_i(accept_symbol_q),
    .ctl_i(ctl), .sts_o(sts),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // A shift, reduce or accept never happens together with a restart.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.do_restart |-> !(ctl.do_shift || ctl.do_reduce || ctl.do_accept))
    else $error("stack update conflict");

  // A stalled result stays valid in the output register.
  a_nolose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped");

endmodule

[bench/lr_parse_engine_test.sv]
// Testbench for the LR parse engine: table loads, grammar runs and a result scoreboard.
`timescale 1ns / 100ps

module lr_parse_engine_test;
  import lrpe_pkg::*;

  localparam int NStates = 256;
  localparam int NSyms   = 64;
  localparam int NRules  = 128;
  localparam int StkMax  = 64;
  localparam int MaxRed  = 15;
  localparam int InW     = $bits(in_item_t);

  // Parser shadow: tables, stack and registers as the block should hold them.
  class parse_scoreboard;
    logic [9:0] act_tbl [NStates*NSyms];
    logic [9:0] rule_tbl [NRules];
    bit         act_wr [NStates*NSyms];
    bit         rule_wr [NRules];
    logic [7:0] stk [StkMax];
    int         sp;
    bit         halt;
    logic [7:0] start_st;
    logic [5:0] acc_sym;
    out_item_t  pending_q[$];
    int         errors;

    function new();
      sp = 0; halt = 1; start_st = 0; acc_sym = 0; errors = 0;
    endfunction

    function void push_res(kind_e k, logic [6:0] rule, bit lst);
      out_item_t r;
      r.kind = k;
      r.rule_reduced = rule;
      r.top_state = (sp == 0) ? 8'd0 : stk[sp-1];
      r.stack_depth = sp[6:0];
      r.last = lst;
      pending_q = {pending_q, r};
    endfunction

    function logic [9:0] look(int s, int y);
      if (s >= NStates || y >= NSyms) return 10'd0;
      return act_wr[s*NSyms+y] ? act_tbl[s*NSyms+y] : 10'd0;
    endfunction

    // Note an accepted input transaction and predict its results.
    function void note_input(in_item_t it);
      int red;
      logic [9:0] e, g, rr;
      int len, lhs;
      red = 0;
      case (act_e'(it.action))
        ACT_LOAD_ENTRY: begin
          act_tbl[it.state_index*NSyms+it.symbol] = {it.command, it.target};
          act_wr[it.state_index*NSyms+it.symbol] = 1;
          push_res(KIND_DONE, 0, 1);
        end
        ACT_LOAD_RULE: begin
          rule_tbl[it.rule_index] = {it.rule_length, it.rule_lhs};
          rule_wr[it.rule_index] = 1;
          push_res(KIND_DONE, 0, 1);
        end
        ACT_RESTART: begin
          stk[0] = start_st; sp = 1; halt = 0;
          push_res(KIND_DONE, 0, 1);
        end
        default: begin
          if (halt || sp == 0) begin
            halt = 1; push_res(KIND_ERROR, 0, 1); return;
          end
          forever begin
            e = look(int'(stk[sp-1]), int'(it.symbol));
            if (cmd_e'(e[9:8]) == CMD_SHIFT) begin
              if (sp >= StkMax) break;
              stk[sp] = e[7:0]; sp++;
              push_res(KIND_SHIFT, 0, 1); return;
            end
            if (cmd_e'(e[9:8]) != CMD_REDUCE || e[7:0] >= NRules || red >= MaxRed) break;
            rr = rule_wr[e[6:0]] ? rule_tbl[e[6:0]] : 10'd0;
            len = int'(rr[9:6]); lhs = int'(rr[5:0]);
            if (len >= sp) break;
            if (lhs == acc_sym) begin
              sp -= len; halt = 1;
              push_res(KIND_ACCEPT, e[6:0], 1); return;
            end
            g = look(int'(stk[sp-len-1]), lhs);
            if (cmd_e'(g[9:8]) != CMD_GOTO) break;
            if (sp - len >= StkMax) break;
            sp -= len; stk[sp] = g[7:0]; sp++; red++;
            push_res(KIND_REDUCE, e[6:0], 0);
          end
          halt = 1;
          push_res(KIND_ERROR, 0, 1);
        end
      endcase
    endfunction

    // Compare one output transaction with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++; return;
      end
      w = pending_q.pop_front();
      if (got.kind !== w.kind) begin
        $display("%0t: kind exp %0d got %0d", $time, w.kind, got.kind); errors++;
      end
      if (got.rule_reduced !== w.rule_reduced) begin
        $display("%0t: rule exp %0d got %0d", $time, w.rule_reduced, got.rule_reduced);
        errors++;
      end
      if (got.top_state !== w.top_state) begin
        $display("%0t: top exp %0d got %0d", $time, w.top_state, got.top_state); errors++;
      end
      if (got.stack_depth !== w.stack_depth) begin
        $display("%0t: depth exp %0d got %0d", $time, w.stack_depth, got.stack_depth);
        errors++;
      end
      if (got.last !== w.last) begin
        $display("%0t: last exp %0d got %0d", $time, w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  out_item_t   out_data_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  parse_scoreboard sb;
  bit          hold_out = 0;
  bit          rx_open = 1;

  always #5 clk_i = ~clk_i;

  lr_parse_engine u_dut (.*);

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Sample output transactions.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Drive receiver stall: random gaps, or a long hold-off when requested.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1;
      end else if (rx_open && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n != 0) begin
          out_stall_i <= 1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 0;
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  // Offer one transaction, hold it until accepted, then drop valid.
  task automatic send_item(in_item_t it, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    repeat (n) @(posedge clk_i);
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 3'(RegStartState * 4)) sb.start_st = val[7:0];
    else sb.acc_sym = val[5:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic in_item_t mk(act_e a);
    in_item_t it;
    it = in_item_t'(InW'({$urandom, $urandom}));
    it.action = a;
    return it;
  endfunction

  task automatic load_entry(int s, int y, cmd_e c, int t, bit gaps);
    in_item_t it;
    it = mk(ACT_LOAD_ENTRY);
    it.state_index = 8'(s); it.symbol = 6'(y); it.command = c; it.target = 8'(t);
    send_item(it, gaps);
  endtask

  task automatic load_rule(int r, int l, int h, bit gaps);
    in_item_t it;
    it = mk(ACT_LOAD_RULE);
    it.rule_index = 7'(r); it.rule_length = 4'(l); it.rule_lhs = 6'(h);
    send_item(it, gaps);
  endtask

  task automatic token(int y, bit gaps);
    in_item_t it;
    it = mk(ACT_TOKEN);
    it.symbol = 6'(y);
    send_item(it, gaps);
  endtask

  // Fill every entry that a token run can read: shifts, reductions, gotos and empty entries.
  task automatic build_grammar(int ns, int nt, int nr, int accsym);
    int s, y, r;
    for (r = 0; r < nr; r++)
      load_rule(r, $urandom_range(0, 3), ($urandom_range(0, 5) == 0) ? accsym
                : $urandom_range(40, 43), 1);
    for (s = 0; s < ns; s++) begin
      for (y = 0; y < nt; y++) begin
        case ($urandom_range(0, 9))
          0: load_entry(s, y, CMD_NONE, $urandom, 1);
          1: load_entry(s, y, CMD_GOTO, $urandom_range(0, ns - 1), 1);
          2, 3, 4: load_entry(s, y, CMD_REDUCE, ($urandom_range(0, 15) == 0) ?
                              $urandom_range(NRules, 255) : $urandom_range(0, nr - 1), 1);
          default: load_entry(s, y, CMD_SHIFT, $urandom_range(0, ns - 1), 1);
        endcase
      end
      for (y = 40; y < 44; y++)
        load_entry(s, y, ($urandom_range(0, 7) == 0) ? CMD_SHIFT : CMD_GOTO,
                   $urandom_range(0, ns - 1), 1);
    end
  endtask

  // Main stimulus sequence.
  initial begin
    int i, k, rounds;
    in_item_t it;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: token while halted, extreme loads, restart.
    token(0, 0);
    load_entry(255, 63, CMD_SHIFT, 255, 0);
    load_entry(255, 0, CMD_NONE, 0, 0);
    load_entry(0, 0, CMD_NONE, 0, 0);
    load_rule(127, 15, 63, 0);
    load_rule(0, 0, 0, 0);
    drain();
    reg_write(3'(RegStartState * 4), 32'd255);
    reg_write(3'(RegAcceptSymbol * 4), 32'd63);
    send_item(mk(ACT_RESTART), 0);
    token(63, 0);              // shift 255 -> 255
    token(0, 0);               // empty entry: error
    drain();
    reg_write(3'(RegStartState * 4), 32'd0);
    send_item(mk(ACT_RESTART), 0);
    load_entry(0, 1, CMD_SHIFT, 0, 0);
    for (i = 0; i < 64; i++) token(1, 0);   // self shift until overflow
    send_item(mk(ACT_RESTART), 0);
    load_entry(0, 2, CMD_REDUCE, 127, 0);
    token(2, 0);               // length 15 underflow
    send_item(mk(ACT_RESTART), 0);
    load_entry(0, 3, CMD_REDUCE, 0, 0);
    load_entry(0, 4, CMD_GOTO, 0, 0);
    load_rule(0, 0, 4, 0);
    token(3, 0);               // reduce loop past the reduction limit
    send_item(mk(ACT_RESTART), 0);
    load_rule(1, 1, 5, 0);
    load_entry(0, 5, CMD_REDUCE, 1, 0);
    token(1, 0);
    token(5, 0);               // accept via lhs 63? no: lhs 5 with no goto: error
    drain();

    // Random grammar on four states, with its accept symbol and a random start state.
    for (rounds = 0; rounds < 1; rounds++) begin
      reg_write(3'(RegAcceptSymbol * 4), 32'(41 + rounds));
      reg_write(3'(RegStartState * 4), 32'($urandom_range(0, 3)));
      build_grammar(4, 4, 6, 41 + rounds);
      drain();
      for (i = 0; i < 12; i++) begin
        if (i == 3) begin
          // Long receiver hold-off while the sender keeps offering.
          fork
            begin hold_out = 1; repeat (300) @(posedge clk_i); hold_out = 0; end
          join_none
        end
        if (i == 8) drain();
        k = $urandom_range(0, 19);
        if (k < 3) send_item(mk(ACT_RESTART), 1);
        else if (k == 3) begin
          it = mk(ACT_LOAD_ENTRY);   // noise load on rows the grammar never reads
          it.state_index = 8'($urandom_range(8, 255));
          send_item(it, 1);
        end else if (k == 4) token($urandom_range(40, 43), 1);
        else token($urandom_range(0, 3), 1);
      end
      drain();
    end
    reg_write(3'(RegStartState * 4), 32'd0);
    reg_write(3'(RegAcceptSymbol * 4), 32'd0);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
